>>> sv/bvot_pkg.sv
// ----------------------------------------------------------------------------
// bvot_pkg
// Shared constants, codes and types for the bounding volume overlap test unit.
// ----------------------------------------------------------------------------
package bvot_pkg;

  // Default coordinate width (signed Q16.8 at the default of 24 bits).
  localparam int COORD_BITS_DEF = 24;

  // Test selection codes carried on the mode field.
  localparam logic [1:0] MODE_CONTAINS_POINT = 2'd0;
  localparam logic [1:0] MODE_CONTAINS_SHAPE = 2'd1;
  localparam logic [1:0] MODE_INTERSECTS     = 2'd2;
  localparam logic [1:0] MODE_TOUCHES        = 2'd3;

  // Configuration register indexes.
  localparam int CFG_IDX_BITS = 3;
  localparam logic [CFG_IDX_BITS-1:0] REG_CENTER_X  = 3'd0;
  localparam logic [CFG_IDX_BITS-1:0] REG_CENTER_Y  = 3'd1;
  localparam logic [CFG_IDX_BITS-1:0] REG_CENTER_Z  = 3'd2;
  localparam logic [CFG_IDX_BITS-1:0] REG_HALF_X    = 3'd3;
  localparam logic [CFG_IDX_BITS-1:0] REG_HALF_Y    = 3'd4;
  localparam logic [CFG_IDX_BITS-1:0] REG_HALF_Z    = 3'd5;
  localparam logic [CFG_IDX_BITS-1:0] REG_RADIUS    = 3'd6;
  localparam logic [CFG_IDX_BITS-1:0] REG_IS_SPHERE = 3'd7;

  // Control passed from the geometry stage to the squared distance stage.
  typedef struct packed {
    logic use_sq;   // Final answer needs the squared distance compare.
    logic strict;   // Compare is "less than" rather than "less or equal".
    logic box_hit;  // Per-axis result, or a gate on the squared compare.
  } bvot_ctl_t;

endpackage

>>> sv/bvot_prep.sv
// ----------------------------------------------------------------------------
// bvot_prep
// Per-axis geometry: center distances, box tests and squared-test operands.
// ----------------------------------------------------------------------------
module bvot_prep #(
  parameter int COORD_BITS = bvot_pkg::COORD_BITS_DEF
) (
  input  logic [1:0]                   mode,
  input  logic                         other_is_sphere,
  input  logic signed [COORD_BITS-1:0] other_center_x,
  input  logic signed [COORD_BITS-1:0] other_center_y,
  input  logic signed [COORD_BITS-1:0] other_center_z,
  input  logic [COORD_BITS-2:0]        other_half_x,
  input  logic [COORD_BITS-2:0]        other_half_y,
  input  logic [COORD_BITS-2:0]        other_half_z,
  input  logic [COORD_BITS-2:0]        other_radius,
  input  logic signed [COORD_BITS-1:0] ref_center_x,
  input  logic signed [COORD_BITS-1:0] ref_center_y,
  input  logic signed [COORD_BITS-1:0] ref_center_z,
  input  logic [COORD_BITS-2:0]        ref_half_x,
  input  logic [COORD_BITS-2:0]        ref_half_y,
  input  logic [COORD_BITS-2:0]        ref_half_z,
  input  logic [COORD_BITS-2:0]        ref_radius,
  input  logic                         ref_is_sphere,
  output bvot_pkg::bvot_ctl_t          ctl,
  output logic [COORD_BITS:0]          v0,
  output logic [COORD_BITS:0]          v1,
  output logic [COORD_BITS:0]          v2,
  output logic [COORD_BITS-1:0]        rad
);

  localparam int CB = COORD_BITS;

  logic [CB-1:0] rc [3];
  logic [CB-1:0] oc [3];
  logic [CB-2:0] rh [3];
  logic [CB-2:0] oh [3];
  logic [CB:0]   diff [3];
  logic [CB:0]   ndiff [3];
  logic [CB-1:0] d [3];
  logic [CB:0]   d_oh [3];
  logic [CB:0]   d_or [3];
  logic [CB-1:0] rh_oh [3];
  logic [CB-2:0] bh [3];
  logic [CB-1:0] clamp [3];
  logic [2:0]    in_pt;
  logic [2:0]    in_bb;
  logic [2:0]    in_bs;
  logic [2:0]    ov_bb;
  logic [2:0]    tch;
  logic [CB:0]   v [3];
  logic          rsph;
  logic          osph;

  always_comb begin
    rc[0] = ref_center_x;
    rc[1] = ref_center_y;
    rc[2] = ref_center_z;
    oc[0] = other_center_x;
    oc[1] = other_center_y;
    oc[2] = other_center_z;
    rh[0] = ref_half_x;
    rh[1] = ref_half_y;
    rh[2] = ref_half_z;
    oh[0] = other_half_x;
    oh[1] = other_half_y;
    oh[2] = other_half_z;
    rsph  = ref_is_sphere;
    osph  = other_is_sphere;

    for (int i = 0; i < 3; i++) begin
      // Absolute center distance; the magnitude always fits in CB bits.
      diff[i]  = {rc[i][CB-1], rc[i]} - {oc[i][CB-1], oc[i]};
      ndiff[i] = -diff[i];
      d[i]     = diff[i][CB] ? ndiff[i][CB-1:0] : diff[i][CB-1:0];
      d_oh[i]  = {1'b0, d[i]} + {2'b00, oh[i]};
      d_or[i]  = {1'b0, d[i]} + {2'b00, other_radius};
      rh_oh[i] = {1'b0, rh[i]} + {1'b0, oh[i]};
      bh[i]    = rsph ? oh[i] : rh[i];
      clamp[i] = (d[i] > {1'b0, bh[i]}) ? (d[i] - {1'b0, bh[i]}) : '0;
      in_pt[i] = d[i] < {1'b0, rh[i]};
      in_bb[i] = d_oh[i] <= {2'b00, rh[i]};
      in_bs[i] = d_or[i] <= {2'b00, rh[i]};
      ov_bb[i] = d[i] <= rh_oh[i];
      tch[i]   = d[i] == rh_oh[i];
    end

    ctl.use_sq  = 1'b0;
    ctl.strict  = 1'b0;
    ctl.box_hit = 1'b0;
    for (int i = 0; i < 3; i++) begin
      v[i] = {1'b0, d[i]};
    end
    rad = {1'b0, ref_radius};

    case (mode)
      bvot_pkg::MODE_CONTAINS_POINT: begin
        if (rsph) begin
          ctl.use_sq  = 1'b1;
          ctl.strict  = 1'b1;
          ctl.box_hit = 1'b1;
        end else begin
          ctl.box_hit = &in_pt;
        end
      end
      bvot_pkg::MODE_CONTAINS_SHAPE: begin
        if (!rsph && !osph) begin
          ctl.box_hit = &in_bb;
        end else if (!rsph) begin
          ctl.box_hit = &in_bs;
        end else if (!osph) begin
          ctl.use_sq  = 1'b1;
          ctl.box_hit = 1'b1;
          for (int i = 0; i < 3; i++) begin
            v[i] = d_oh[i];
          end
        end else begin
          // The inner sphere must not be larger than the outer one.
          ctl.use_sq  = 1'b1;
          ctl.box_hit = other_radius <= ref_radius;
          rad         = {1'b0, ref_radius} - {1'b0, other_radius};
        end
      end
      bvot_pkg::MODE_INTERSECTS: begin
        if (!rsph && !osph) begin
          ctl.box_hit = &ov_bb;
        end else if (rsph && osph) begin
          ctl.use_sq  = 1'b1;
          ctl.box_hit = 1'b1;
          rad         = {1'b0, ref_radius} + {1'b0, other_radius};
        end else begin
          // Closest point on the box to the sphere center.
          ctl.use_sq  = 1'b1;
          ctl.box_hit = 1'b1;
          rad         = {1'b0, (rsph ? ref_radius : other_radius)};
          for (int i = 0; i < 3; i++) begin
            v[i] = {1'b0, clamp[i]};
          end
        end
      end
      bvot_pkg::MODE_TOUCHES: begin
        // At least two axes must meet exactly; spheres never touch here.
        if (!rsph && !osph) begin
          ctl.box_hit = (tch[0] & tch[1]) | (tch[0] & tch[2]) | (tch[1] & tch[2]);
        end
      end
      default: begin
        ctl.box_hit = 1'b0;
      end
    endcase
  end

  assign v0 = v[0];
  assign v1 = v[1];
  assign v2 = v[2];

endmodule

>>> sv/bvot_sqcmp.sv
// ----------------------------------------------------------------------------
// bvot_sqcmp
// Squares the three axis operands and the radius, then sums and compares.
// ----------------------------------------------------------------------------
module bvot_sqcmp #(
  parameter int COORD_BITS = bvot_pkg::COORD_BITS_DEF
) (
  input  logic                  clk,
  input  logic                  rst_n,
  input  logic                  in_vld,
  input  bvot_pkg::bvot_ctl_t   ctl,
  input  logic [COORD_BITS:0]   v0,
  input  logic [COORD_BITS:0]   v1,
  input  logic [COORD_BITS:0]   v2,
  input  logic [COORD_BITS-1:0] rad,
  output logic                  out_valid,
  output logic                  out_hit
);

  localparam int SQW  = 2 * COORD_BITS + 2;
  localparam int RSQW = 2 * COORD_BITS;
  localparam int SUMW = SQW + 2;

  logic                vld_r;
  logic                vld_nxt;
  bvot_pkg::bvot_ctl_t ctl_r;
  logic [SQW-1:0]      sq0_r;
  logic [SQW-1:0]      sq1_r;
  logic [SQW-1:0]      sq2_r;
  logic [RSQW-1:0]     rsq_r;
  logic [SUMW-1:0]     sum;
  logic [SUMW-1:0]     rsq_ext;
  logic                cmp;
  logic                out_valid_r;
  logic                out_valid_nxt;
  logic                out_hit_r;
  logic                out_hit_nxt;

  assign vld_nxt = in_vld;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vld_r <= 1'b0;
    end else begin
      vld_r <= vld_nxt;
    end
  end

  always_ff @(posedge clk) begin
    ctl_r <= ctl;
    sq0_r <= SQW'(v0) * SQW'(v0);
    sq1_r <= SQW'(v1) * SQW'(v1);
    sq2_r <= SQW'(v2) * SQW'(v2);
    rsq_r <= RSQW'(rad) * RSQW'(rad);
  end

  always_comb begin
    sum         = SUMW'(sq0_r) + SUMW'(sq1_r) + SUMW'(sq2_r);
    rsq_ext     = SUMW'(rsq_r);
    cmp         = ctl_r.strict ? (sum < rsq_ext) : (sum <= rsq_ext);
    out_hit_nxt = ctl_r.box_hit & (~ctl_r.use_sq | cmp);
  end

  assign out_valid_nxt = vld_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else begin
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    out_hit_r <= out_hit_nxt;
  end

  assign out_valid = out_valid_r;
  assign out_hit   = out_hit_r;

endmodule

>>> sv/bounding_volume_overlap_test_unit.sv
// ----------------------------------------------------------------------------
// bounding_volume_overlap_test_unit
// Tests a stream of points, boxes and spheres against one reference volume.
// ----------------------------------------------------------------------------
// The unit takes one request in every clock cycle and never stalls: busy is
// held low, so a request is transferred whenever start is high. Each request
// produces exactly one result, presented on out_hit for a single cycle with
// out_valid high, in request order. The strobe comes from the result
// register, behind the request, geometry and multiplier registers. The
// receiver cannot hold results off and must take each one as it appears.
// The pipeline has four registers: the request register, the per-axis
// geometry register, the multiplier register (three axis squares and the
// squared radius) and the result register. The multipliers of COORD_BITS+1
// by COORD_BITS+1 bits set the clock rate; the sum-and-compare stage after
// them is a single wide add and compare.
//
// The reference volume lives in eight configuration registers written through
// cfg_we, cfg_index and cfg_data: center x, y and z, half extents x, y and z,
// the radius, and the sphere select flag, at indexes 0 through 7. Writes take
// effect at the next edge and should only be issued while no request is in
// flight, since the pipeline reads the registers while working on a request.
// Coordinates are signed fixed point (Q16.8 at the default width); halves and
// the radius use the low COORD_BITS-1 bits of cfg_data, the flag uses bit 0.
// All sums and squares are carried at full width, so no test can overflow.
// ----------------------------------------------------------------------------
module bounding_volume_overlap_test_unit #(
  parameter int COORD_BITS = bvot_pkg::COORD_BITS_DEF
) (
  input  logic                                  clk,
  input  logic                                  rst_n,
  input  logic                                  start,
  output logic                                  busy,
  input  logic [1:0]                            in_mode,
  input  logic                                  in_other_is_sphere,
  input  logic signed [COORD_BITS-1:0]          in_other_center_x,
  input  logic signed [COORD_BITS-1:0]          in_other_center_y,
  input  logic signed [COORD_BITS-1:0]          in_other_center_z,
  input  logic [COORD_BITS-2:0]                 in_other_half_x,
  input  logic [COORD_BITS-2:0]                 in_other_half_y,
  input  logic [COORD_BITS-2:0]                 in_other_half_z,
  input  logic [COORD_BITS-2:0]                 in_other_radius,
  input  logic                                  cfg_we,
  input  logic [bvot_pkg::CFG_IDX_BITS-1:0]     cfg_index,
  input  logic [COORD_BITS-1:0]                 cfg_data,
  output logic                                  out_valid,
  output logic                                  out_hit
);

  localparam int CB = COORD_BITS;

  // Reference volume registers.
  logic signed [CB-1:0] ref_center_x_r;
  logic signed [CB-1:0] ref_center_y_r;
  logic signed [CB-1:0] ref_center_z_r;
  logic [CB-2:0]        ref_half_x_r;
  logic [CB-2:0]        ref_half_y_r;
  logic [CB-2:0]        ref_half_z_r;
  logic [CB-2:0]        ref_radius_r;
  logic                 ref_is_sphere_r;

  // Request register.
  logic                 req_vld_r;
  logic                 req_vld_nxt;
  logic [1:0]           mode_r;
  logic                 other_is_sphere_r;
  logic signed [CB-1:0] other_center_x_r;
  logic signed [CB-1:0] other_center_y_r;
  logic signed [CB-1:0] other_center_z_r;
  logic [CB-2:0]        other_half_x_r;
  logic [CB-2:0]        other_half_y_r;
  logic [CB-2:0]        other_half_z_r;
  logic [CB-2:0]        other_radius_r;

  // Geometry stage outputs and their register.
  bvot_pkg::bvot_ctl_t  geo_ctl;
  logic [CB:0]          geo_v0;
  logic [CB:0]          geo_v1;
  logic [CB:0]          geo_v2;
  logic [CB-1:0]        geo_rad;
  logic                 geo_vld_r;
  logic                 geo_vld_nxt;
  bvot_pkg::bvot_ctl_t  geo_ctl_r;
  logic [CB:0]          geo_v0_r;
  logic [CB:0]          geo_v1_r;
  logic [CB:0]          geo_v2_r;
  logic [CB-1:0]        geo_rad_r;

  // The pipeline advances every cycle, so a new request is always welcome.
  assign busy = 1'b0;

  // Configuration writes. Every index of the port names a register.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      ref_center_x_r  <= '0;
      ref_center_y_r  <= '0;
      ref_center_z_r  <= '0;
      ref_half_x_r    <= '0;
      ref_half_y_r    <= '0;
      ref_half_z_r    <= '0;
      ref_radius_r    <= '0;
      ref_is_sphere_r <= 1'b0;
    end else if (cfg_we) begin
      case (cfg_index)
        bvot_pkg::REG_CENTER_X:  ref_center_x_r  <= cfg_data;
        bvot_pkg::REG_CENTER_Y:  ref_center_y_r  <= cfg_data;
        bvot_pkg::REG_CENTER_Z:  ref_center_z_r  <= cfg_data;
        bvot_pkg::REG_HALF_X:    ref_half_x_r    <= cfg_data[CB-2:0];
        bvot_pkg::REG_HALF_Y:    ref_half_y_r    <= cfg_data[CB-2:0];
        bvot_pkg::REG_HALF_Z:    ref_half_z_r    <= cfg_data[CB-2:0];
        bvot_pkg::REG_RADIUS:    ref_radius_r    <= cfg_data[CB-2:0];
        bvot_pkg::REG_IS_SPHERE: ref_is_sphere_r <= cfg_data[0];
        default: begin
          ref_is_sphere_r <= ref_is_sphere_r;
        end
      endcase
    end
  end

  // Request capture: a transfer happens on every edge with start high.
  assign req_vld_nxt = start & ~busy;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      req_vld_r <= 1'b0;
    end else begin
      req_vld_r <= req_vld_nxt;
    end
  end

  always_ff @(posedge clk) begin
    mode_r            <= in_mode;
    other_is_sphere_r <= in_other_is_sphere;
    other_center_x_r  <= in_other_center_x;
    other_center_y_r  <= in_other_center_y;
    other_center_z_r  <= in_other_center_z;
    other_half_x_r    <= in_other_half_x;
    other_half_y_r    <= in_other_half_y;
    other_half_z_r    <= in_other_half_z;
    other_radius_r    <= in_other_radius;
  end

  // Per-axis distances, box-only tests and operand selection for the
  // squared distance test.
  bvot_prep #(
    .COORD_BITS (COORD_BITS)
  ) u_prep (
    .mode            (mode_r),
    .other_is_sphere (other_is_sphere_r),
    .other_center_x  (other_center_x_r),
    .other_center_y  (other_center_y_r),
    .other_center_z  (other_center_z_r),
    .other_half_x    (other_half_x_r),
    .other_half_y    (other_half_y_r),
    .other_half_z    (other_half_z_r),
    .other_radius    (other_radius_r),
    .ref_center_x    (ref_center_x_r),
    .ref_center_y    (ref_center_y_r),
    .ref_center_z    (ref_center_z_r),
    .ref_half_x      (ref_half_x_r),
    .ref_half_y      (ref_half_y_r),
    .ref_half_z      (ref_half_z_r),
    .ref_radius      (ref_radius_r),
    .ref_is_sphere   (ref_is_sphere_r),
    .ctl             (geo_ctl),
    .v0              (geo_v0),
    .v1              (geo_v1),
    .v2              (geo_v2),
    .rad             (geo_rad)
  );

  assign geo_vld_nxt = req_vld_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      geo_vld_r <= 1'b0;
    end else begin
      geo_vld_r <= geo_vld_nxt;
    end
  end

  always_ff @(posedge clk) begin
    geo_ctl_r <= geo_ctl;
    geo_v0_r  <= geo_v0;
    geo_v1_r  <= geo_v1;
    geo_v2_r  <= geo_v2;
    geo_rad_r <= geo_rad;
  end

  // Squares, sum and final compare; drives the result strobe and flag.
  bvot_sqcmp #(
    .COORD_BITS (COORD_BITS)
  ) u_sqcmp (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_vld    (geo_vld_r),
    .ctl       (geo_ctl_r),
    .v0        (geo_v0_r),
    .v1        (geo_v1_r),
    .v2        (geo_v2_r),
    .rad       (geo_rad_r),
    .out_valid (out_valid),
    .out_hit   (out_hit)
  );

endmodule
